[hdl/aalu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aalu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned OpW = 4;
  localparam logic [DataW-1:0] MaxRegIndex = 8'h09;
  localparam logic [DataW-1:0] ShiftLimit = 8'd8;

  typedef enum logic [OpW-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_AND     = 4'd2,
    OP_OR      = 4'd3,
    OP_XOR     = 4'd4,
    OP_NOT     = 4'd5,
    OP_SHR     = 4'd6,
    OP_SHL     = 4'd7,
    OP_CMP     = 4'd8,
    OP_REG_ADD = 4'd9,
    OP_REG_SUB = 4'd10,
    OP_REG_AND = 4'd11,
    OP_REG_OR  = 4'd12,
    OP_REG_XOR = 4'd13,
    OP_SWAP    = 4'd14
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [DataW-1:0] acc_in;
    logic [DataW-1:0] operand;
    logic [DataW-1:0] register_value;
    logic             zero_in;
    logic             carry_in;
    logic             equal_in;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] acc_out;
    logic             zero_out;
    logic             carry_out;
    logic             equal_out;
    logic             bad_register;
  } out_t;

endpackage

`default_nettype wire

[hdl/accumulator_alu_8bit_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// 8-bit accumulator ALU.
// Input channel: in_valid_i / in_stall_o / in_data_i carry one operation with
// the accumulator, operand, register value and current flags. A transfer
// happens on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i / out_data_o return the new
// accumulator, the zero, carry and equal flags and the bad-register flag.
// Path: an operation passes the input register, the ALU logic and the result
// register before out_valid_o rises. Throughput: one operation per cycle while
// the receiver does not stall, set by the single ALU pass between the two
// register stages.
// When the receiver stalls, the result register holds; the input register
// takes one more transfer, then in_stall_o rises until the result leaves.
// Stall propagates combinationally from out_stall_i to in_stall_o.
// Reset clears both valid bits; nothing is in flight afterward.
module accumulator_alu_8bit_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire aalu_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output aalu_pkg::out_t      out_data_o
);
  import aalu_pkg::*;

  logic s1_valid_q, s1_valid_d;
  in_t  s1_data_q;
  logic s2_valid_q, s2_valid_d;
  out_t s2_data_q;
  out_t alu_res;
  logic s2_load;
  logic s1_load;

  aalu_exec u_exec (
    .op_i  (s1_data_q),
    .res_o (alu_res)
  );

  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= in_data_i;
    end
    if (s2_load) begin
      s2_data_q <= alu_res;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule

`default_nettype wire

[hdl/aalu_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

module aalu_exec (
  input  wire aalu_pkg::in_t op_i,
  output aalu_pkg::out_t     res_o
);
  import aalu_pkg::*;

  logic [DataW-1:0] acc;
  logic [DataW-1:0] b;
  logic [DataW:0]   sum;
  logic [DataW-1:0] diff;
  logic             borrow;
  logic             is_reg;
  logic             reg_ok;
  logic             shift_big;
  logic [DataW-1:0] acc_new;
  logic             set_zero;

  assign acc       = op_i.acc_in;
  assign is_reg    = (op_i.operation == OP_REG_ADD) || (op_i.operation == OP_REG_SUB) ||
                     (op_i.operation == OP_REG_AND) || (op_i.operation == OP_REG_OR) ||
                     (op_i.operation == OP_REG_XOR);
  assign b         = is_reg ? op_i.register_value : op_i.operand;
  assign sum       = {1'b0, acc} + {1'b0, b};
  assign diff      = acc - b;
  assign borrow    = b > acc;
  assign reg_ok    = op_i.operand <= MaxRegIndex;
  assign shift_big = op_i.operand >= ShiftLimit;

  always_comb begin
    acc_new            = acc;
    set_zero           = 1'b0;
    res_o.carry_out    = op_i.carry_in;
    res_o.equal_out    = op_i.equal_in;
    res_o.bad_register = 1'b0;
    unique case (op_i.operation)
      OP_ADD: begin
        acc_new         = sum[DataW-1:0];
        res_o.carry_out = sum[DataW];
        set_zero        = 1'b1;
      end
      OP_SUB: begin
        acc_new         = diff;
        res_o.carry_out = borrow;
        set_zero        = 1'b1;
      end
      OP_AND: begin
        acc_new  = acc & b;
        set_zero = 1'b1;
      end
      OP_OR: begin
        acc_new  = acc | b;
        set_zero = 1'b1;
      end
      OP_XOR: begin
        acc_new  = acc ^ b;
        set_zero = 1'b1;
      end
      OP_NOT: begin
        acc_new  = ~acc;
        set_zero = 1'b1;
      end
      OP_SHR: begin
        acc_new  = shift_big ? '0 : (acc >> op_i.operand[2:0]);
        set_zero = 1'b1;
      end
      OP_SHL: begin
        acc_new  = shift_big ? '0 : (acc << op_i.operand[2:0]);
        set_zero = 1'b1;
      end
      OP_CMP: begin
        res_o.equal_out = acc == op_i.operand;
      end
      OP_REG_ADD, OP_REG_SUB, OP_REG_AND, OP_REG_OR, OP_REG_XOR: begin
        if (!reg_ok) begin
          res_o.bad_register = 1'b1;
        end else begin
          set_zero = 1'b1;
          unique case (op_i.operation)
            OP_REG_ADD: begin
              acc_new         = sum[DataW-1:0];
              res_o.carry_out = sum[DataW];
            end
            OP_REG_SUB: begin
              acc_new         = diff;
              res_o.carry_out = borrow;
            end
            OP_REG_AND: begin
              acc_new         = acc & b;
              res_o.carry_out = sum[DataW];
            end
            OP_REG_OR: begin
              acc_new         = acc | b;
              res_o.carry_out = sum[DataW];
            end
            default: begin
              acc_new         = acc ^ b;
              res_o.carry_out = sum[DataW];
            end
          endcase
        end
      end
      OP_SWAP: begin
        acc_new = {acc[3:0], acc[7:4]};
      end
      default: begin
        acc_new = acc;
      end
    endcase
    res_o.acc_out  = acc_new;
    res_o.zero_out = set_zero ? (acc_new == '0) : op_i.zero_in;
  end

endmodule

`default_nettype wire
